// ----- hdl/gaps_pkg.sv -----
// Package for the grid path search block: command and status codes and the
// packed beat types of the input and result channels.
// No dependencies.
package gaps_pkg;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FINISH_BLOCKED = 2'd1;
    localparam logic [1:0] ST_NO_PATH  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] cell_row;
        logic [4:0] cell_col;
        logic       blocked;
        logic [4:0] goal_row;
        logic [4:0] goal_col;
        logic [9:0] step_index;
    } gaps_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] path_length;
        logic [4:0] step_row;
        logic [4:0] step_col;
    } gaps_out_t;

endpackage

// ----- hdl/grid_astar_path_search.sv -----
// One beat is in flight at a time. Writes, spare commands, failed reads and finishes off
// the map answer from S_IDLE; reads go through S_RD. A search with a blocked finish or a
// start off the map answers from S_GCHK; otherwise it clears the node store (S_CLRN), then
// per expansion scans the open entries (S_SA, S_SB, S_SC), shifts the later ones down
// (S_DEL, S_DW), closes the best and tries four neighbours (S_NA, S_NB), and traces the
// path back (S_BT0, S_BT1). After reset the blocked map is cleared cell by cell before the
// first beat; both dimensions return to 32. Top level of the grid path search block; one
// module with its memories. Depends on gaps_pkg.
module grid_astar_path_search
    import gaps_pkg::*;
#(
    parameter int GRID_SIDE = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  gaps_in_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output gaps_out_t   m_item
);

    localparam int CW = $clog2(GRID_SIDE);
    localparam int AW = 2 * CW;
    localparam int MD = 1 << AW;
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int GW = AW + 1;
    localparam int FW = AW + 2;
    localparam int LW = GW + 10;
    localparam int DW = $clog2(GRID_SIDE + 1);
    localparam int NW = (DW > 6) ? DW : 6;
    localparam int NDW = GW + 4;

    typedef enum logic [4:0] {
        S_CLRB, S_IDLE, S_RD, S_GCHK, S_CLRN, S_INIT, S_SCAN0, S_SA, S_SB, S_SC,
        S_DEL, S_DW, S_CLOSE, S_NA, S_NB, S_BT0, S_BT1
    } state_t;

    function automatic logic [CW-1:0] f5c(input logic [4:0] x);
        logic [CW+4:0] t;
        t = {{CW{1'b0}}, x};
        return t[CW-1:0];
    endfunction

    function automatic logic [4:0] c2f(input logic [CW-1:0] x);
        logic [CW+4:0] t;
        t = {5'b0, x};
        return t[4:0];
    endfunction

    function automatic logic [CW-1:0] absd(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [9:0] sat10(input logic [GW-1:0] v);
        logic [LW-1:0] t;
        t = {{10{1'b0}}, v};
        if (t > LW'(1023)) begin
            return 10'd1023;
        end
        return t[9:0];
    endfunction

    logic [5:0]     rows_reg, cols_reg;
    state_t         state_reg;
    logic [AW-1:0]  clr_reg;
    logic [NW-1:0]  nr_reg, nc_reg;
    logic [AW-1:0]  start_reg, goal_reg;
    logic           start_bad_reg;
    logic [AW:0]    open_cnt_reg;
    logic [AW-1:0]  scan_i_reg, best_i_reg, scan_cell_reg, best_cell_reg;
    logic [FW-1:0]  best_f_reg;
    logic [NDW-1:0] best_word_reg;
    logic [AW:0]    del_i_reg;
    logic [AW-1:0]  cur_reg, nb_reg, bt_c_reg;
    logic [GW-1:0]  cur_g_reg, bt_k_reg, path_len_reg;
    logic [1:0]     dir_reg;
    logic           m_valid_reg;
    gaps_out_t      m_item_reg;

    logic           blk_mem [MD];
    logic [NDW-1:0] node_mem [MD];
    logic [AW-1:0]  open_mem [MD];
    logic [AW-1:0]  path_mem [MD];
    logic           blk_rd_reg;
    logic [NDW-1:0] node_rd_reg;
    logic [AW-1:0]  open_rd_reg, path_rd_reg;

    logic           blk_we, blk_wdata, node_we, open_we, path_we;
    logic [AW-1:0]  blk_waddr, blk_raddr, node_waddr, node_raddr;
    logic [AW-1:0]  open_waddr, open_raddr, path_waddr, path_raddr, open_wdata, path_wdata;
    logic [NDW-1:0] node_wdata;

    logic           accept;
    logic [NW-1:0]  nr_now, nc_now;
    logic [CW-1:0]  cur_r, cur_c, bt_r, bt_cc, par_r, par_c;
    logic           nb_ok;
    logic [AW-1:0]  nb_addr, par_addr;
    logic [FW-1:0]  scan_f;
    logic [GW-1:0]  tg;
    logic [LW-1:0]  idx_ext;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_COLS) ? {26'b0, cols_reg} : {26'b0, rows_reg};
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 6'd32;
            cols_reg <= 6'd32;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_COLS) begin
                cols_reg <= pwdata[5:0];
            end else begin
                rows_reg <= pwdata[5:0];
            end
        end
    end

    always_comb begin
        nr_now = (NW'(rows_reg) < NW'(GRID_SIDE)) ? NW'(rows_reg) : NW'(GRID_SIDE);
        nc_now = (NW'(cols_reg) < NW'(GRID_SIDE)) ? NW'(cols_reg) : NW'(GRID_SIDE);
        idx_ext = {{GW{1'b0}}, s_item.step_index};
        cur_r = cur_reg[AW-1:CW];
        cur_c = cur_reg[CW-1:0];
        nb_ok = 1'b0;
        nb_addr = cur_reg;
        unique case (dir_reg)
            2'd0: begin
                nb_ok = (cur_r != '0);
                nb_addr = {cur_r - CW'(1), cur_c};
            end
            2'd1: begin
                nb_ok = (cur_c != '0);
                nb_addr = {cur_r, cur_c - CW'(1)};
            end
            2'd2: begin
                nb_ok = (NW'(cur_r) + NW'(1) < nr_reg);
                nb_addr = {cur_r + CW'(1), cur_c};
            end
            default: begin
                nb_ok = (NW'(cur_c) + NW'(1) < nc_reg);
                nb_addr = {cur_r, cur_c + CW'(1)};
            end
        endcase
        bt_r = bt_c_reg[AW-1:CW];
        bt_cc = bt_c_reg[CW-1:0];
        par_r = bt_r;
        par_c = bt_cc;
        unique case (node_rd_reg[GW+1:GW])
            2'd0: par_r = (bt_r == CW'(GRID_SIDE - 1)) ? '0 : bt_r + CW'(1);
            2'd1: par_c = (bt_cc == CW'(GRID_SIDE - 1)) ? '0 : bt_cc + CW'(1);
            2'd2: par_r = (bt_r == '0) ? CW'(GRID_SIDE - 1) : bt_r - CW'(1);
            default: par_c = (bt_cc == '0) ? CW'(GRID_SIDE - 1) : bt_cc - CW'(1);
        endcase
        par_addr = {par_r, par_c};
        scan_f = FW'(node_rd_reg[GW-1:0])
               + FW'(absd(goal_reg[AW-1:CW], scan_cell_reg[AW-1:CW]))
               + FW'(absd(goal_reg[CW-1:0], scan_cell_reg[CW-1:0]));
        tg = cur_g_reg + GW'(1);

        blk_we = 1'b0;
        blk_waddr = clr_reg;
        blk_wdata = 1'b0;
        blk_raddr = nb_reg;
        node_we = 1'b0;
        node_waddr = clr_reg;
        node_wdata = '0;
        node_raddr = nb_reg;
        open_we = 1'b0;
        open_waddr = open_cnt_reg[AW-1:0];
        open_wdata = nb_reg;
        open_raddr = scan_i_reg;
        path_we = 1'b0;
        path_waddr = bt_k_reg[AW-1:0] - AW'(1);
        path_wdata = bt_c_reg;
        path_raddr = idx_ext[AW-1:0];
        unique case (state_reg)
            S_CLRB: blk_we = 1'b1;
            S_IDLE: begin
                blk_raddr = {f5c(s_item.goal_row), f5c(s_item.goal_col)};
                if (accept && s_item.cmd == CMD_WRITE && 9'(s_item.cell_row) < 9'(GRID_SIDE)
                        && 9'(s_item.cell_col) < 9'(GRID_SIDE)) begin
                    blk_we = 1'b1;
                    blk_waddr = {f5c(s_item.cell_row), f5c(s_item.cell_col)};
                    blk_wdata = s_item.blocked;
                end
            end
            S_CLRN: node_we = 1'b1;
            S_INIT: begin
                node_we = 1'b1;
                node_waddr = start_reg;
                node_wdata = {2'b01, 2'd0, {GW{1'b0}}};
                open_we = 1'b1;
                open_waddr = '0;
                open_wdata = start_reg;
            end
            S_SA: open_raddr = scan_i_reg;
            S_SB: node_raddr = open_rd_reg;
            S_DEL: open_raddr = del_i_reg[AW-1:0];
            S_DW: begin
                open_we = 1'b1;
                open_waddr = del_i_reg[AW-1:0] - AW'(1);
                open_wdata = open_rd_reg;
            end
            S_CLOSE: begin
                node_we = 1'b1;
                node_waddr = best_cell_reg;
                node_wdata = {2'b10, best_word_reg[GW+1:0]};
            end
            S_NA: begin
                node_raddr = nb_addr;
                blk_raddr = nb_addr;
            end
            S_NB: begin
                if (!blk_rd_reg && !node_rd_reg[NDW-1]) begin
                    if (!node_rd_reg[NDW-2] || tg < node_rd_reg[GW-1:0]) begin
                        node_we = 1'b1;
                        node_waddr = nb_reg;
                        node_wdata = {2'b01, dir_reg, tg};
                    end
                    if (!node_rd_reg[NDW-2] && open_cnt_reg < (AW+1)'(CELLS)) begin
                        open_we = 1'b1;
                    end
                end
            end
            S_BT0: node_raddr = cur_reg;
            S_BT1: begin
                path_we = 1'b1;
                node_raddr = par_addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (blk_we) begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_rd_reg <= blk_mem[blk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge aclk) begin
        if (open_we) begin
            open_mem[open_waddr] <= open_wdata;
        end
        open_rd_reg <= open_mem[open_raddr];
    end

    always_ff @(posedge aclk) begin
        if (path_we) begin
            path_mem[path_waddr] <= path_wdata;
        end
        path_rd_reg <= path_mem[path_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLRB;
            clr_reg <= '0;
            open_cnt_reg <= '0;
            path_len_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !accept) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLRB: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (&clr_reg) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        m_item_reg.step_row <= '0;
                        m_item_reg.step_col <= '0;
                        case (s_item.cmd)
                            CMD_SEARCH: begin
                                nr_reg <= nr_now;
                                nc_reg <= nc_now;
                                start_reg <= {f5c(s_item.cell_row), f5c(s_item.cell_col)};
                                goal_reg <= {f5c(s_item.goal_row), f5c(s_item.goal_col)};
                                start_bad_reg <= (NW'(s_item.cell_row) >= nr_now)
                                              || (NW'(s_item.cell_col) >= nc_now);
                                if (NW'(s_item.goal_row) >= nr_now
                                        || NW'(s_item.goal_col) >= nc_now) begin
                                    path_len_reg <= '0;
                                    m_item_reg.status <= ST_FINISH_BLOCKED;
                                    m_item_reg.path_length <= '0;
                                    m_valid_reg <= 1'b1;
                                end else begin
                                    m_valid_reg <= 1'b0;
                                    state_reg <= S_GCHK;
                                end
                            end
                            CMD_READ: begin
                                m_item_reg.path_length <= sat10(path_len_reg);
                                if (idx_ext < {{10{1'b0}}, path_len_reg}
                                        && idx_ext < LW'(CELLS)) begin
                                    m_item_reg.status <= ST_OK;
                                    m_valid_reg <= 1'b0;
                                    state_reg <= S_RD;
                                end else begin
                                    m_item_reg.status <= ST_RANGE;
                                    m_valid_reg <= 1'b1;
                                end
                            end
                            default: begin
                                m_item_reg.status <= ST_OK;
                                m_item_reg.path_length <= sat10(path_len_reg);
                                m_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    m_item_reg.step_row <= c2f(path_rd_reg[AW-1:CW]);
                    m_item_reg.step_col <= c2f(path_rd_reg[CW-1:0]);
                    m_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_GCHK: begin
                    path_len_reg <= '0;
                    clr_reg <= '0;
                    if (blk_rd_reg || start_bad_reg) begin
                        m_item_reg.status <= blk_rd_reg ? ST_FINISH_BLOCKED : ST_NO_PATH;
                        m_item_reg.path_length <= '0;
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_CLRN;
                    end
                end
                S_CLRN: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (&clr_reg) begin
                        state_reg <= S_INIT;
                    end
                end
                S_INIT: begin
                    open_cnt_reg <= (AW+1)'(1);
                    state_reg <= S_SCAN0;
                end
                S_SCAN0: begin
                    scan_i_reg <= '0;
                    best_f_reg <= '1;
                    best_i_reg <= '0;
                    if (open_cnt_reg == '0) begin
                        m_item_reg.status <= ST_NO_PATH;
                        m_item_reg.path_length <= '0;
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_SA;
                    end
                end
                S_SA: state_reg <= S_SB;
                S_SB: begin
                    scan_cell_reg <= open_rd_reg;
                    state_reg <= S_SC;
                end
                S_SC: begin
                    if (scan_f <= best_f_reg) begin
                        best_f_reg <= scan_f;
                        best_i_reg <= scan_i_reg;
                        best_cell_reg <= scan_cell_reg;
                        best_word_reg <= node_rd_reg;
                    end
                    scan_i_reg <= scan_i_reg + AW'(1);
                    if ((AW+1)'(scan_i_reg) + (AW+1)'(1) == open_cnt_reg) begin
                        del_i_reg <= (scan_f <= best_f_reg)
                                   ? (AW+1)'(scan_i_reg) + (AW+1)'(1)
                                   : (AW+1)'(best_i_reg) + (AW+1)'(1);
                        state_reg <= S_DEL;
                    end else begin
                        state_reg <= S_SA;
                    end
                end
                S_DEL: begin
                    if (del_i_reg == open_cnt_reg) begin
                        open_cnt_reg <= open_cnt_reg - (AW+1)'(1);
                        state_reg <= S_CLOSE;
                    end else begin
                        state_reg <= S_DW;
                    end
                end
                S_DW: begin
                    del_i_reg <= del_i_reg + (AW+1)'(1);
                    state_reg <= S_DEL;
                end
                S_CLOSE: begin
                    cur_reg <= best_cell_reg;
                    cur_g_reg <= best_word_reg[GW-1:0];
                    dir_reg <= 2'd0;
                    state_reg <= (best_cell_reg == goal_reg) ? S_BT0 : S_NA;
                end
                S_NA: begin
                    nb_reg <= nb_addr;
                    if (nb_ok) begin
                        state_reg <= S_NB;
                    end else begin
                        dir_reg <= dir_reg + 2'd1;
                        if (dir_reg == 2'd3) begin
                            state_reg <= S_SCAN0;
                        end
                    end
                end
                S_NB: begin
                    if (open_we) begin
                        open_cnt_reg <= open_cnt_reg + (AW+1)'(1);
                    end
                    dir_reg <= dir_reg + 2'd1;
                    state_reg <= (dir_reg == 2'd3) ? S_SCAN0 : S_NA;
                end
                S_BT0: begin
                    bt_c_reg <= cur_reg;
                    bt_k_reg <= cur_g_reg;
                    if (cur_reg == start_reg || cur_g_reg == '0) begin
                        path_len_reg <= cur_g_reg;
                        m_item_reg.status <= ST_OK;
                        m_item_reg.path_length <= sat10(cur_g_reg);
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_BT1;
                    end
                end
                S_BT1: begin
                    bt_c_reg <= par_addr;
                    bt_k_reg <= bt_k_reg - GW'(1);
                    if (par_addr == start_reg || bt_k_reg == GW'(1)) begin
                        path_len_reg <= cur_g_reg;
                        m_item_reg.status <= ST_OK;
                        m_item_reg.path_length <= sat10(cur_g_reg);
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_take_while_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input beat taken while a result beat is still waiting");
    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        open_cnt_reg <= (AW+1)'(CELLS))
        else $error("open list count exceeds the number of cells");
    a_del_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEL) |-> (del_i_reg <= open_cnt_reg && del_i_reg != '0))
        else $error("open list removal index out of range");
`endif

endmodule

// ----- tb/sv/grid_astar_path_search_test.sv -----
// Self-checking testbench for grid_astar_path_search: loads blocked cells, runs searches
// and reads path steps over several grid sizes, predicting every answer with its own A* search.
// Depends on gaps_pkg and grid_astar_path_search.
module grid_astar_path_search_test;
    import gaps_pkg::*;

    localparam int SIDE = 32;
    localparam int STALL_LIMIT = 4000000;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    gaps_in_t    s_item;
    logic        m_valid;
    logic        m_ready;
    gaps_out_t   m_item;

    grid_astar_path_search #(.GRID_SIDE(SIDE)) dut (.*);

    gaps_in_t  pending_beats[$];
    gaps_out_t awaited_answers[$];
    int errors = 0;
    int n_sent = 0;
    int n_answered = 0;
    int n_searches = 0;
    int n_found = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    bit held = 0;

    // Predictor state.
    logic [5:0] rows_reg = 6'd32;
    logic [5:0] cols_reg = 6'd32;
    bit   wall [SIDE*SIDE];
    bit   shut [SIDE*SIDE];
    bit   queued [SIDE*SIDE];
    int   g_score [SIDE*SIDE];
    logic [1:0] came [SIDE*SIDE];
    int   frontier [SIDE*SIDE];
    int   n_frontier;
    int   route [SIDE*SIDE];
    int   route_len = 0;

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
    end

    function automatic int span(input int a, input int b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic logic [1:0] find_route(input int sr, input int sc, input int gr,
                                              input int gc, input int nr, input int nc);
        int start_cell, goal_cell, best_f, pick, f, cur, cr, cc, r, c, n, tg, k, len;
        bit found;
        start_cell = sr * SIDE + sc;
        goal_cell = gr * SIDE + gc;
        found = 0;
        for (int i = 0; i < SIDE*SIDE; i++) begin
            shut[i] = 0;
            queued[i] = 0;
        end
        route_len = 0;
        frontier[0] = start_cell;
        n_frontier = 1;
        queued[start_cell] = 1;
        g_score[start_cell] = 0;
        came[start_cell] = 0;
        while (n_frontier > 0) begin
            best_f = 1 << 30;
            pick = 0;
            for (int i = 0; i < n_frontier; i++) begin
                f = g_score[frontier[i]] + span(gr, frontier[i] / SIDE)
                    + span(gc, frontier[i] % SIDE);
                if (f <= best_f) begin
                    best_f = f;
                    pick = i;
                end
            end
            cur = frontier[pick];
            for (int i = pick + 1; i < n_frontier; i++) frontier[i-1] = frontier[i];
            n_frontier--;
            queued[cur] = 0;
            shut[cur] = 1;
            if (cur == goal_cell) begin
                found = 1;
                break;
            end
            cr = cur / SIDE;
            cc = cur % SIDE;
            for (int d = 0; d < 4; d++) begin
                r = cr + (d == 0 ? -1 : d == 2 ? 1 : 0);
                c = cc + (d == 1 ? -1 : d == 3 ? 1 : 0);
                if (r < 0 || c < 0 || r >= nr || c >= nc) continue;
                n = r * SIDE + c;
                if (wall[n] || shut[n]) continue;
                tg = g_score[cur] + 1;
                if (!queued[n]) begin
                    queued[n] = 1;
                    g_score[n] = tg;
                    came[n] = d[1:0];
                    frontier[n_frontier] = n;
                    n_frontier++;
                end else if (tg < g_score[n]) begin
                    g_score[n] = tg;
                    came[n] = d[1:0];
                end
            end
        end
        if (!found) return ST_NO_PATH;
        len = g_score[goal_cell];
        k = len;
        c = goal_cell;
        while (c != start_cell && k > 0) begin
            k--;
            route[k] = c;
            r = c / SIDE;
            cc = c % SIDE;
            case (came[c])
                2'd0: r = r + 1;
                2'd1: cc = cc + 1;
                2'd2: r = r - 1;
                default: cc = cc - 1;
            endcase
            c = r * SIDE + cc;
        end
        route_len = len;
        return ST_OK;
    endfunction

    function automatic gaps_out_t predict_answer(input gaps_in_t it);
        gaps_out_t a;
        int nr, nc;
        a = '0;
        nr = rows_reg < SIDE ? rows_reg : SIDE;
        nc = cols_reg < SIDE ? cols_reg : SIDE;
        case (it.cmd)
            CMD_SEARCH: begin
                n_searches++;
                if (it.goal_row >= nr || it.goal_col >= nc
                        || wall[it.goal_row * SIDE + it.goal_col]) begin
                    a.status = ST_FINISH_BLOCKED;
                    route_len = 0;
                end else if (it.cell_row >= nr || it.cell_col >= nc) begin
                    a.status = ST_NO_PATH;
                    route_len = 0;
                end else begin
                    a.status = find_route(it.cell_row, it.cell_col, it.goal_row, it.goal_col,
                                          nr, nc);
                    if (a.status == ST_OK) n_found++;
                end
            end
            CMD_READ: begin
                if (it.step_index < route_len) begin
                    a.step_row = 5'(route[it.step_index] / SIDE);
                    a.step_col = 5'(route[it.step_index] % SIDE);
                end else begin
                    a.status = ST_RANGE;
                end
            end
            CMD_WRITE: wall[it.cell_row * SIDE + it.cell_col] = it.blocked;
            default: ;
        endcase
        a.path_length = route_len > 1023 ? 10'd1023 : route_len[9:0];
        return a;
    endfunction

    function automatic void add_beat(input gaps_in_t it);
        pending_beats = {pending_beats, it};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            s_item <= '0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_answers = {awaited_answers, predict_answer(s_item)};
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_beats.size() > 0
                        && ((n_sent > 60 && n_sent < 95) || $urandom_range(99) >= 10)) begin
                    s_item <= pending_beats.pop_front();
                    s_valid <= 1;
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_answers.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %p", $time, m_item);
                    errors++;
                end else begin
                    gaps_out_t want;
                    want = awaited_answers.pop_front();
                    if (m_item.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time, want.status,
                                 m_item.status);
                        errors++;
                    end
                    if (m_item.path_length !== want.path_length) begin
                        $display("%0t: path_length expected %0d actual %0d", $time,
                                 want.path_length, m_item.path_length);
                        errors++;
                    end
                    if (m_item.step_row !== want.step_row) begin
                        $display("%0t: step_row expected %0d actual %0d", $time, want.step_row,
                                 m_item.step_row);
                        errors++;
                    end
                    if (m_item.step_col !== want.step_col) begin
                        $display("%0t: step_col expected %0d actual %0d", $time, want.step_col,
                                 m_item.step_col);
                        errors++;
                    end
                end
                n_answered++;
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 0;
            end else if (n_answered == 30 && !held) begin
                held <= 1;
                hold_left <= 400;
                m_ready <= 0;
            end else begin
                m_ready <= (n_answered > 60 && n_answered < 95) || $urandom_range(99) >= 10;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic gaps_in_t make_beat(input logic [1:0] cmd, input int row, input int col,
                                           input int blk, input int gr, input int gc,
                                           input int idx);
        gaps_in_t it;
        it = '0;
        it.cmd = cmd;
        it.cell_row = 5'(row);
        it.cell_col = 5'(col);
        it.blocked = blk[0];
        it.goal_row = 5'(gr);
        it.goal_col = 5'(gc);
        it.step_index = 10'(idx);
        return it;
    endfunction

    function automatic int pick_coord(input int n);
        if (n == 0 || $urandom_range(99) < 12) return $urandom_range(31);
        return $urandom_range(n - 1);
    endfunction

    function automatic int nudge(input int v, input int n);
        int w;
        w = v + $urandom_range(12) - 6;
        if (w < 0) w = 0;
        if (w > n - 1) w = n - 1;
        return w;
    endfunction

    task automatic queue_random(input int count, input int nr, input int nc, input bit near);
        int kind, sr, sc, gr, gc, idx;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            sr = pick_coord(nr);
            sc = pick_coord(nc);
            if (kind < 35) begin
                add_beat(make_beat(CMD_WRITE, sr, sc, int'($urandom_range(99) < 40),
                                   $urandom, $urandom, $urandom));
            end else if (kind < 65) begin
                gr = near ? nudge(sr, nr) : pick_coord(nr);
                gc = near ? nudge(sc, nc) : pick_coord(nc);
                add_beat(make_beat(CMD_SEARCH, sr, sc, $urandom, gr, gc, $urandom));
            end else if (kind < 95) begin
                idx = $urandom_range(99) < 10 ? $urandom_range(1023) : $urandom_range(24);
                add_beat(make_beat(CMD_READ, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, idx));
            end else begin
                add_beat(make_beat(CMD_SPARE, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom));
            end
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_beats.size() > 0 || s_valid || awaited_answers.size() > 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_dim(input logic which, input logic [5:0] value);
        @(posedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {which, 2'b00};
        pwdata <= {26'b0, value};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (which == REG_ROWS) rows_reg = value;
        else cols_reg = value;
    endtask

    task automatic run_phase(input int rows, input int cols, input int count);
        write_dim(REG_ROWS, 6'(rows));
        write_dim(REG_COLS, 6'(cols));
        queue_random(count, rows > SIDE ? SIDE : rows, cols > SIDE ? SIDE : cols, 0);
        wait_drained();
    endtask

    initial begin
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < SIDE*SIDE; i++) wall[i] = 0;
        wait (aresetn === 1'b1);

        add_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0));
        add_beat(make_beat(CMD_SEARCH, 3, 3, 1, 3, 3, 0));
        add_beat(make_beat(CMD_SEARCH, 0, 0, 0, 31, 31, 1023));
        add_beat(make_beat(CMD_READ, 31, 31, 1, 31, 31, 0));
        add_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 61));
        add_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 62));
        add_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 1023));
        add_beat(make_beat(CMD_WRITE, 31, 31, 1, 0, 0, 0));
        add_beat(make_beat(CMD_SEARCH, 0, 0, 0, 31, 31, 0));
        add_beat(make_beat(CMD_WRITE, 31, 31, 0, 31, 31, 1023));
        add_beat(make_beat(CMD_WRITE, 5, 5, 1, 0, 0, 0));
        add_beat(make_beat(CMD_SEARCH, 5, 5, 0, 5, 9, 0));
        add_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 3));
        add_beat(make_beat(CMD_WRITE, 5, 5, 0, 0, 0, 0));
        add_beat(make_beat(CMD_SPARE, 31, 31, 1, 31, 31, 1023));
        add_beat(make_beat(CMD_SEARCH, 31, 31, 1, 0, 0, 0));
        add_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0));
        wait_drained();

        write_dim(REG_ROWS, 6'd32);
        write_dim(REG_COLS, 6'd32);
        queue_random(16, SIDE, SIDE, 1);
        wait_drained();

        write_dim(REG_ROWS, 6'd1);
        write_dim(REG_COLS, 6'd8);
        add_beat(make_beat(CMD_WRITE, 0, 3, 1, 0, 0, 0));
        add_beat(make_beat(CMD_SEARCH, 0, 0, 0, 0, 6, 0));
        add_beat(make_beat(CMD_SEARCH, 0, 9, 0, 0, 1, 0));
        add_beat(make_beat(CMD_SEARCH, 0, 6, 0, 0, 4, 0));
        add_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 1));
        queue_random(12, 1, 8, 0);
        wait_drained();

        run_phase(8, 1, 14);
        run_phase(6, 5, 20);
        run_phase(4, 4, 18);
        run_phase(1, 1, 8);
        run_phase(0, 3, 6);
        run_phase(40, 2, 14);
        run_phase(7, 7, 20);

        $display("Covered %0d beats, %0d searches of which %0d found a route,", n_sent,
                 n_searches, n_found);
        $display("over grids from empty to 32 by 32 with input and output back-pressure.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
